>>> rtl/core/bresenham_line_raster_defines.svh
`ifndef BRESENHAM_LINE_RASTER_DEFINES_SVH
`define BRESENHAM_LINE_RASTER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BLR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BLR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/blr_pkg.sv
package blr_pkg;

    localparam int COORD_W        = 6;
    localparam int COLOR_W        = 8;
    localparam int COORD_BITS_DEF = 6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic cmd_ready;
        logic load;
        logic setup;
        logic pix_valid;
        logic step;
    } ctrl_t;

endpackage

>>> rtl/core/blr_step.sv
module blr_step import blr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int D_W        = COORD_BITS + 4
) (
    input  logic                         rising,
    input  logic signed [D_W-1:0]        d,
    input  logic signed [D_W-1:0]        inc_hold,
    input  logic signed [D_W-1:0]        inc_move,
    input  logic        [COORD_BITS-1:0] maj,
    input  logic        [COORD_BITS-1:0] mnr,
    output logic signed [D_W-1:0]        d_next,
    output logic        [COORD_BITS-1:0] maj_next,
    output logic        [COORD_BITS-1:0] mnr_next
);

    logic                  d_pos;
    logic                  move;
    logic signed [D_W-1:0] inc;

    // minor axis moves when the midpoint falls on the far side
    assign d_pos    = (d > 0);
    assign move     = rising ? d_pos : !d_pos;
    assign inc      = move ? inc_move : inc_hold;
    assign d_next   = d + inc;
    assign maj_next = maj + COORD_BITS'(1);

    always_comb
    begin
        if (!move)
        begin
            mnr_next = mnr;
        end
        else if (rising)
        begin
            mnr_next = mnr + COORD_BITS'(1);
        end
        else
        begin
            mnr_next = mnr - COORD_BITS'(1);
        end
    end

endmodule

>>> rtl/core/blr_fsm.sv
`include "bresenham_line_raster_defines.svh"

module blr_fsm import blr_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cmd_valid,
    input  logic  pix_ready,
    input  logic  fin,
    output ctrl_t ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (pix_ready && fin)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctrl.cmd_ready = 1'b1;
                ctrl.load      = cmd_valid;
            end
            ST_SETUP:
            begin
                ctrl.setup = 1'b1;
            end
            ST_RUN:
            begin
                ctrl.pix_valid = 1'b1;
                ctrl.step      = pix_ready && !fin;
            end
            default:
            begin
                ctrl = '0;
            end
        endcase
    end

    `BLR_ASSERT_SAME(a_no_overlap, clk, rst_n, 1'b1, !(ctrl.cmd_ready && ctrl.pix_valid), "ready while a word is pending")
    `BLR_ASSERT_NEXT(a_load_setup, clk, rst_n, ctrl.load, state_reg == ST_SETUP, "load not followed by setup")
    `BLR_ASSERT_NEXT(a_setup_run, clk, rst_n, ctrl.setup, ctrl.pix_valid, "setup not followed by output")
    `BLR_ASSERT_NEXT(a_last_idle, clk, rst_n, ctrl.pix_valid && pix_ready && fin, ctrl.cmd_ready, "no return to idle after last word")

endmodule

>>> rtl/core/bresenham_line_raster.sv
// the accepted command is latched, the setup state registers the line parameters,
// and in the run state the first pixel word can be taken; one decision adder steps
// a line's n pixels (major extent + 1, up to 64) one a cycle while pix_ready is high
// cmd_ready stays low from acceptance until the last word is taken
// rst_n clears the sequencer to idle asynchronously; data registers are not reset
module bresenham_line_raster import blr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [COLOR_W-1:0] color,
    output logic               pix_valid,
    input  logic               pix_ready,
    output logic [COORD_W-1:0] point_x,
    output logic [COORD_W-1:0] point_y,
    output logic [COLOR_W-1:0] pixel_value,
    output logic               last
);

    localparam int CB  = COORD_BITS;
    localparam int D_W = COORD_BITS + 4;

    ctrl_t ctrl;

    logic [CB-1:0]         ax_reg, ay_reg, bx_reg, by_reg;
    logic [COLOR_W-1:0]    color_reg;
    logic [CB-1:0]         maj_reg, mnr_reg, maj_end_reg;
    logic signed [D_W-1:0] d_reg, inc_hold_reg, inc_move_reg;
    logic                  rising_reg, along_x_reg;

    logic signed [CB:0]    ex, ey, aex, aey;
    logic                  along_x, swap;
    logic [CB-1:0]         sax, say, sbx, sby;
    logic [CB-1:0]         maj0, mnr0, maj_end0;
    logic signed [CB:0]    dmaj, dmin;
    logic signed [D_W-1:0] dmaj_w, dmin_w;
    logic                  rising0;
    logic signed [D_W-1:0] d0, inc_hold0, inc_move0;

    logic signed [D_W-1:0] d_next;
    logic [CB-1:0]         maj_next, mnr_next;
    logic                  fin;

    // line setup from the latched endpoints
    always_comb
    begin
        ex      = signed'({1'b0, bx_reg}) - signed'({1'b0, ax_reg});
        ey      = signed'({1'b0, by_reg}) - signed'({1'b0, ay_reg});
        aex     = ex[CB] ? -ex : ex;
        aey     = ey[CB] ? -ey : ey;
        along_x = aex > aey;
        swap    = along_x ? (bx_reg < ax_reg) : (by_reg < ay_reg);
        sax     = swap ? bx_reg : ax_reg;
        say     = swap ? by_reg : ay_reg;
        sbx     = swap ? ax_reg : bx_reg;
        sby     = swap ? ay_reg : by_reg;
        if (along_x)
        begin
            maj0     = sax;
            mnr0     = say;
            maj_end0 = sbx;
            dmaj     = signed'({1'b0, sbx}) - signed'({1'b0, sax});
            dmin     = signed'({1'b0, sby}) - signed'({1'b0, say});
        end
        else
        begin
            maj0     = say;
            mnr0     = sax;
            maj_end0 = sby;
            dmaj     = signed'({1'b0, sby}) - signed'({1'b0, say});
            dmin     = signed'({1'b0, sbx}) - signed'({1'b0, sax});
        end
        dmaj_w    = D_W'(dmaj);
        dmin_w    = D_W'(dmin);
        rising0   = !dmin[CB];
        inc_hold0 = dmin_w <<< 1;
        d0        = rising0 ? (inc_hold0 - dmaj_w) : (inc_hold0 + dmaj_w);
        inc_move0 = rising0 ? ((dmin_w - dmaj_w) <<< 1) : ((dmin_w + dmaj_w) <<< 1);
    end

    assign fin = (maj_reg >= maj_end_reg);

    blr_fsm u_fsm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .pix_ready (pix_ready),
        .fin       (fin),
        .ctrl      (ctrl)
    );

    blr_step #(
        .COORD_BITS (COORD_BITS),
        .D_W        (D_W)
    ) u_step (
        .rising   (rising_reg),
        .d        (d_reg),
        .inc_hold (inc_hold_reg),
        .inc_move (inc_move_reg),
        .maj      (maj_reg),
        .mnr      (mnr_reg),
        .d_next   (d_next),
        .maj_next (maj_next),
        .mnr_next (mnr_next)
    );

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ax_reg    <= start_x[CB-1:0];
            ay_reg    <= start_y[CB-1:0];
            bx_reg    <= end_x[CB-1:0];
            by_reg    <= end_y[CB-1:0];
            color_reg <= color;
        end
        if (ctrl.setup)
        begin
            maj_reg      <= maj0;
            mnr_reg      <= mnr0;
            maj_end_reg  <= maj_end0;
            d_reg        <= d0;
            inc_hold_reg <= inc_hold0;
            inc_move_reg <= inc_move0;
            rising_reg   <= rising0;
            along_x_reg  <= along_x;
        end
        else if (ctrl.step)
        begin
            maj_reg <= maj_next;
            mnr_reg <= mnr_next;
            d_reg   <= d_next;
        end
    end

    assign cmd_ready   = ctrl.cmd_ready;
    assign pix_valid   = ctrl.pix_valid;
    assign point_x     = COORD_W'(along_x_reg ? maj_reg : mnr_reg);
    assign point_y     = COORD_W'(along_x_reg ? mnr_reg : maj_reg);
    assign pixel_value = color_reg;
    assign last        = fin;

endmodule

>>> tb/sv/bresenham_line_raster_checker.sv
module bresenham_line_raster_checker import blr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  logic               cmd_ready,
    input  logic [COORD_W-1:0] start_x,
    input  logic [COORD_W-1:0] start_y,
    input  logic [COORD_W-1:0] end_x,
    input  logic [COORD_W-1:0] end_y,
    input  logic [COLOR_W-1:0] color,
    input  logic               pix_valid,
    input  logic               pix_ready,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COLOR_W-1:0] pixel_value,
    input  logic               last,
    output int                 fail_count,
    output int                 pending_pixels,
    output int                 line_count,
    output int                 pixel_count,
    output int                 x_major_count
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COLOR_W-1:0] value;
        logic               last;
    } pixel_t;

    pixel_t expected_pixels[$];
    int     mismatches;
    int     lines_drawn;
    int     x_major_lines;
    int     checked_pixels;

    // midpoint line walk, one expected word per pixel
    function automatic void trace_line(input logic [COORD_W-1:0] sx,
                                       input logic [COORD_W-1:0] sy,
                                       input logic [COORD_W-1:0] ex,
                                       input logic [COORD_W-1:0] ey,
                                       input logic [COLOR_W-1:0] shade);
        int     mask, ax, ay, bx, by, swap, span_x, span_y;
        int     major, minor, major_end, d_major, d_minor, decision, count;
        bit     along_x, rising, fin;
        pixel_t px;
        mask = (1 << COORD_BITS) - 1;
        ax = int'(sx) & mask;
        ay = int'(sy) & mask;
        bx = int'(ex) & mask;
        by = int'(ey) & mask;
        span_x = (bx > ax) ? bx - ax : ax - bx;
        span_y = (by > ay) ? by - ay : ay - by;
        along_x = span_x > span_y;
        if ((along_x && bx < ax) || (!along_x && by < ay))
        begin
            swap = ax;
            ax = bx;
            bx = swap;
            swap = ay;
            ay = by;
            by = swap;
        end
        if (along_x)
        begin
            major = ax;
            minor = ay;
            major_end = bx;
            d_major = bx - ax;
            d_minor = by - ay;
        end
        else
        begin
            major = ay;
            minor = ax;
            major_end = by;
            d_major = by - ay;
            d_minor = bx - ax;
        end
        rising = d_minor >= 0;
        decision = rising ? 2 * d_minor - d_major : 2 * d_minor + d_major;
        count = 0;
        fin = 1'b0;
        while (!fin)
        begin
            fin = major >= major_end;
            px.x = COORD_W'((along_x ? major : minor) & mask);
            px.y = COORD_W'((along_x ? minor : major) & mask);
            px.value = shade;
            px.last = fin;
            expected_pixels.push_back(px);
            count++;
            if (count >= 64)
                fin = 1'b1;
            if (!fin)
            begin
                if (rising)
                begin
                    if (decision <= 0)
                        decision += 2 * d_minor;
                    else
                    begin
                        decision += 2 * (d_minor - d_major);
                        minor++;
                    end
                end
                else
                begin
                    if (decision <= 0)
                    begin
                        decision += 2 * (d_minor + d_major);
                        minor--;
                    end
                    else
                        decision += 2 * d_minor;
                end
                major++;
            end
        end
        lines_drawn++;
        if (along_x)
            x_major_lines++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            expected_pixels.delete();
            mismatches     = 0;
            lines_drawn    = 0;
            x_major_lines  = 0;
            checked_pixels = 0;
        end
        else
        begin
            if (pix_valid && pix_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected pixel word x=%0d y=%0d value=%0d last=%0d",
                                 point_x, point_y, pixel_value, last);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (point_x !== want.x || point_y !== want.y ||
                        pixel_value !== want.value || last !== want.last)
                    begin
                        if (mismatches < 10)
                        begin
                            $display("pixel %0d mismatch: expected x=%0d y=%0d value=%0d last=%0d",
                                     checked_pixels, want.x, want.y, want.value, want.last);
                            $display("    got x=%0d y=%0d value=%0d last=%0d",
                                     point_x, point_y, pixel_value, last);
                        end
                        mismatches++;
                    end
                end
                checked_pixels++;
            end
            if (cmd_valid && cmd_ready)
                trace_line(start_x, start_y, end_x, end_y, color);
        end
        fail_count     <= mismatches;
        pending_pixels <= expected_pixels.size();
        line_count     <= lines_drawn;
        pixel_count    <= checked_pixels;
        x_major_count  <= x_major_lines;
    end

endmodule

>>> tb/sv/bresenham_line_raster_tb.sv
module bresenham_line_raster_tb;

    import blr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_LINES = 447;
    localparam int DRAIN_LIMIT  = 20000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_ready;
    logic [COORD_W-1:0] start_x = '0;
    logic [COORD_W-1:0] start_y = '0;
    logic [COORD_W-1:0] end_x = '0;
    logic [COORD_W-1:0] end_y = '0;
    logic [COLOR_W-1:0] color = '0;
    logic               pix_valid;
    logic               pix_ready = 1'b0;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [COLOR_W-1:0] pixel_value;
    logic               last;

    int fail_count;
    int pending_pixels;
    int line_count;
    int pixel_count;
    int x_major_count;

    int burst_left;
    int stall_left;
    int window_left;
    int rx_mode;

    always #10 clk = ~clk;

    bresenham_line_raster dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .color       (color),
        .pix_valid   (pix_valid),
        .pix_ready   (pix_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .pixel_value (pixel_value),
        .last        (last)
    );

    bresenham_line_raster_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .color          (color),
        .pix_valid      (pix_valid),
        .pix_ready      (pix_ready),
        .point_x        (point_x),
        .point_y        (point_y),
        .pixel_value    (pixel_value),
        .last           (last),
        .fail_count     (fail_count),
        .pending_pixels (pending_pixels),
        .line_count     (line_count),
        .pixel_count    (pixel_count),
        .x_major_count  (x_major_count)
    );

    // receiver: windows of always-ready, light stalls and heavy stalls
    always @(posedge clk)
    begin
        bit go;
        go = 1'b1;
        if (window_left <= 0)
        begin
            rx_mode = $urandom_range(0, 2);
            window_left = $urandom_range(16, 96);
        end
        window_left--;
        if (stall_left > 0)
        begin
            stall_left--;
            go = 1'b0;
        end
        else if (rx_mode == 1 && $urandom_range(0, 3) == 0)
        begin
            stall_left = $urandom_range(0, 1);
            go = 1'b0;
        end
        else if (rx_mode == 2 && $urandom_range(0, 1) == 0)
        begin
            stall_left = $urandom_range(0, 5);
            go = 1'b0;
        end
        pix_ready <= go;
    end

    task automatic send_line(input logic [COORD_W-1:0] sx, input logic [COORD_W-1:0] sy,
                             input logic [COORD_W-1:0] ex, input logic [COORD_W-1:0] ey,
                             input logic [COLOR_W-1:0] shade);
        int gap;
        cmd_valid <= 1'b1;
        start_x   <= sx;
        start_y   <= sy;
        end_x     <= ex;
        end_y     <= ey;
        color     <= shade;
        do
            @(posedge clk);
        while (!cmd_ready);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 7);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        int waited;
        cmd_valid <= 1'b0;
        waited = 0;
        do
        begin
            @(posedge clk);
            waited++;
        end
        while (pending_pixels != 0 && waited < DRAIN_LIMIT);
    endtask

    function automatic logic [COORD_W-1:0] near(input logic [COORD_W-1:0] v);
        int lo, hi;
        lo = (v < 4) ? 0 : int'(v) - 4;
        hi = (v > 59) ? 63 : int'(v) + 4;
        return COORD_W'($urandom_range(lo, hi));
    endfunction

    initial
    begin
        logic [COORD_W-1:0] sx, sy, ex, ey, swap;
        int                 kind, span;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_line(0, 0, 0, 0, 8'h00);
        send_line(63, 63, 63, 63, 8'hFF);
        send_line(0, 0, 63, 0, 8'hAA);
        send_line(63, 63, 0, 63, 8'h55);
        send_line(0, 0, 0, 63, 8'h0F);
        send_line(63, 63, 63, 0, 8'hF0);
        send_line(0, 0, 63, 63, 8'h01);
        send_line(63, 0, 0, 63, 8'h80);
        send_line(63, 63, 0, 0, 8'h7F);
        send_line(0, 63, 63, 0, 8'hFE);
        send_line(0, 0, 2, 1, 8'h11);
        send_line(0, 1, 2, 0, 8'h22);
        send_line(0, 0, 1, 2, 8'h33);
        send_line(1, 0, 0, 2, 8'h44);
        send_line(42, 21, 21, 42, 8'hAA);
        send_line(21, 42, 42, 21, 8'h55);
        send_line(5, 10, 60, 30, 8'h66);
        send_line(60, 10, 5, 30, 8'h77);
        send_line(10, 5, 30, 60, 8'h88);
        send_line(30, 5, 10, 60, 8'h99);
        send_line(0, 0, 63, 1, 8'hC3);
        send_line(0, 1, 63, 0, 8'h3C);
        send_line(1, 0, 0, 63, 8'h5A);
        wait_idle();

        for (int i = 0; i < RANDOM_LINES; i++)
        begin
            kind = $urandom_range(0, 9);
            sx = COORD_W'($urandom_range(0, 63));
            sy = COORD_W'($urandom_range(0, 63));
            ex = COORD_W'($urandom_range(0, 63));
            ey = COORD_W'($urandom_range(0, 63));
            if (kind == 6 || kind == 7)
            begin
                ex = near(sx);
                ey = near(sy);
            end
            else if (kind == 8)
            begin
                if ($urandom_range(0, 1) == 1)
                    ey = sy;
                else
                    ex = sx;
            end
            else if (kind == 9)
            begin
                span = $urandom_range(0, 63);
                sx = COORD_W'($urandom_range(0, 63 - span));
                sy = COORD_W'($urandom_range(0, 63 - span));
                ex = sx + COORD_W'(span);
                ey = sy + COORD_W'(span);
                if ($urandom_range(0, 1) == 1)
                begin
                    sx = 6'd63 - sx;
                    ex = 6'd63 - ex;
                end
                if ($urandom_range(0, 1) == 1)
                begin
                    swap = sx;
                    sx = ex;
                    ex = swap;
                    swap = sy;
                    sy = ey;
                    ey = swap;
                end
            end
            send_line(sx, sy, ex, ey, COLOR_W'($urandom_range(0, 255)));
            if (i % 100 == 99)
                wait_idle();
        end

        wait_idle();
        repeat (8) @(posedge clk);
        $display("drew %0d lines (%0d scanned along x, %0d along y), %0d pixel words checked",
                 line_count, x_major_count, line_count - x_major_count, pixel_count);
        if (fail_count == 0 && pending_pixels == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #25ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
